[sv/apqe_pkg.sv]
// Shared constants, types and slot arithmetic for the aging particle quad emitter.
package apqe_pkg;

   localparam int MaxParticles = 16;
   localparam int IdxW         = (MaxParticles > 1) ? $clog2(MaxParticles) : 1;
   localparam int CntW         = $clog2(MaxParticles + 1);

   localparam int PosW   = 20;
   localparam int VertW  = 21;
   localparam int LifeW  = 26;
   localparam int FullW  = 24;
   localparam int DeltaW = 20;
   localparam int TexW   = 12;
   localparam int ColorW = 8;
   localparam int CsrW   = 24;

   localparam logic [FullW-1:0] FullLifetimeReset = 24'd1000000;
   localparam logic [CsrW-1:0]  BaseRgbReset      = 24'hFFFFFF;
   localparam logic [TexW-1:0]  TexSizeReset      = 12'd16;

   localparam logic [ColorW-1:0] AlphaFloor = 8'd127;
   localparam logic [ColorW-1:0] AlphaMax   = 8'd255;

   typedef logic [IdxW-1:0] idx_type;
   typedef logic [CntW-1:0] cnt_type;
   typedef logic [CntW:0]   slot_sum_type;

   typedef enum logic [1:0] {
      OpAdd  = 2'd0,
      OpTick = 2'd1,
      OpDraw = 2'd2,
      OpNone = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      RegFullLifetime = 2'd0,
      RegBaseRgb      = 2'd1,
      RegTexWidth     = 2'd2,
      RegTexHeight    = 2'd3
   } csr_index_type;

   function automatic idx_type slot_of(idx_type head, cnt_type offset);
      slot_sum_type sum;
      sum = slot_sum_type'(head) + slot_sum_type'(offset);
      if (sum >= slot_sum_type'(MaxParticles)) begin
         sum = sum - slot_sum_type'(MaxParticles);
      end
      return idx_type'(sum);
   endfunction

endpackage

[sv/aging_particle_quad_emitter_unit.sv]
// Particle FIFO with aging ticks and per-particle quad corner emission.
// Add and empty draw finish on acceptance in StIdle; req_stall is high in every other state.
// Tick: StPop pops each expired particle at the head and checks the head again; StDecay then
//   decrements each remaining life. Draw: per particle StLoad reads it, StDivide forms alpha
//   when life is strictly between half and full, StShow sets up, StEmit sends 4 beats held on rsp_stall.
// Synchronous reset empties the FIFO and restores the register defaults; stores stay as they are.
module aging_particle_quad_emitter_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_opcode,
   input  logic signed [apqe_pkg::PosW-1:0]   req_pos_x,
   input  logic signed [apqe_pkg::PosW-1:0]   req_pos_y,
   input  logic [apqe_pkg::DeltaW-1:0]        req_delta_time,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [apqe_pkg::VertW-1:0]  rsp_vert_x,
   output logic signed [apqe_pkg::VertW-1:0]  rsp_vert_y,
   output logic [apqe_pkg::TexW-1:0]          rsp_tex_u,
   output logic [apqe_pkg::TexW-1:0]          rsp_tex_v,
   output logic [apqe_pkg::ColorW-1:0]        rsp_red,
   output logic [apqe_pkg::ColorW-1:0]        rsp_green,
   output logic [apqe_pkg::ColorW-1:0]        rsp_blue,
   output logic [apqe_pkg::ColorW-1:0]        rsp_alpha,
   output logic                               rsp_last,
   input  logic                               csr_write_en,
   input  logic [1:0]                         csr_index,
   input  logic [apqe_pkg::CsrW-1:0]          csr_data
);

   typedef enum logic [2:0] {
      StIdle,
      StPop,
      StDecay,
      StLoad,
      StDivide,
      StShow,
      StEmit
   } state_type;

   typedef enum logic [1:0] {
      CornerTopLeft     = 2'd0,
      CornerTopRight    = 2'd1,
      CornerBottomRight = 2'd2,
      CornerBottomLeft  = 2'd3
   } corner_type;

   localparam int VertW = apqe_pkg::VertW;
   localparam int LifeW = apqe_pkg::LifeW;
   localparam int FullW = apqe_pkg::FullW;

   // configuration
   logic [FullW-1:0]              full_lifetime_ff;
   logic [apqe_pkg::CsrW-1:0]     base_rgb_ff;
   logic [apqe_pkg::TexW-1:0]     tex_width_ff;
   logic [apqe_pkg::TexW-1:0]     tex_height_ff;

   // particle stores
   logic signed [apqe_pkg::PosW-1:0] store_x_ff    [apqe_pkg::MaxParticles];
   logic signed [apqe_pkg::PosW-1:0] store_y_ff    [apqe_pkg::MaxParticles];
   logic signed [LifeW-1:0]          store_life_ff [apqe_pkg::MaxParticles];

   // control state
   state_type             state_ff, state_in;
   apqe_pkg::idx_type     head_ff, head_in;
   apqe_pkg::cnt_type     count_ff, count_in;
   apqe_pkg::cnt_type     walk_ff, walk_in;
   corner_type            corner_ff, corner_in;
   logic [2:0]            div_step_ff, div_step_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [apqe_pkg::DeltaW-1:0] delta_ff, delta_in;
   logic signed [VertW-1:0]     x_lo_ff, x_lo_in, x_hi_ff, x_hi_in;
   logic signed [VertW-1:0]     y_lo_ff, y_lo_in, y_hi_ff, y_hi_in;
   logic [FullW-1:0]            rem_ff, rem_in;
   logic [7:0]                  num_lo_ff, num_lo_in;
   logic [7:0]                  alpha_ff, alpha_in;

   // output beat
   logic signed [VertW-1:0]        rsp_vert_x_ff, rsp_vert_y_ff;
   logic [apqe_pkg::TexW-1:0]      rsp_tex_u_ff, rsp_tex_v_ff;
   logic [apqe_pkg::ColorW-1:0]    rsp_red_ff, rsp_green_ff, rsp_blue_ff, rsp_alpha_ff;
   logic                           rsp_last_ff;

   // datapath
   logic                    req_take;
   apqe_pkg::idx_type       walk_slot;
   apqe_pkg::idx_type       add_slot;
   logic signed [LifeW-1:0] rd_life;
   logic signed [LifeW:0]   decay_diff;
   logic signed [LifeW-1:0] decay_life;
   logic                    add_en;
   logic                    decay_en;
   logic                    half_or_less;
   logic                    full_or_more;
   logic [31:0]             scaled_life;
   logic [FullW:0]          trial;
   logic                    trial_fits;
   logic [VertW-1:0]        half_w;
   logic [VertW-1:0]        half_h;
   logic                    rsp_load;
   corner_type              load_corner;
   logic                    walk_is_last;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != StIdle);

   assign walk_slot = apqe_pkg::slot_of(head_ff, walk_ff);
   assign add_slot  = apqe_pkg::slot_of(head_ff, count_ff);
   assign rd_life   = store_life_ff[walk_slot];

   assign decay_diff = {rd_life[LifeW-1], rd_life} - $signed({7'd0, delta_ff});
   assign decay_life = (decay_diff[LifeW] && !decay_diff[LifeW-1])
                     ? {1'b1, {(LifeW-1){1'b0}}} : decay_diff[LifeW-1:0];

   assign half_or_less = $signed({rd_life, 1'b0}) <= $signed({3'd0, full_lifetime_ff});
   assign full_or_more = rd_life >= $signed({2'd0, full_lifetime_ff});
   assign scaled_life  = {rd_life[FullW-1:0], 8'd0} - {8'd0, rd_life[FullW-1:0]};

   assign trial      = {rem_ff, num_lo_ff[7]};
   assign trial_fits = trial >= {1'b0, full_lifetime_ff};

   assign half_w = VertW'({tex_width_ff, 3'd0});
   assign half_h = VertW'({tex_height_ff, 3'd0});

   assign walk_is_last = (apqe_pkg::cnt_type'(walk_ff + 1'b1) == count_ff);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      walk_in      = walk_ff;
      corner_in    = corner_ff;
      div_step_in  = div_step_ff;
      rsp_valid_in = rsp_valid_ff;
      delta_in     = delta_ff;
      x_lo_in      = x_lo_ff;
      x_hi_in      = x_hi_ff;
      y_lo_in      = y_lo_ff;
      y_hi_in      = y_hi_ff;
      rem_in       = rem_ff;
      num_lo_in    = num_lo_ff;
      alpha_in     = alpha_ff;
      add_en       = 1'b0;
      decay_en     = 1'b0;
      rsp_load     = 1'b0;
      load_corner  = CornerTopLeft;

      case (state_ff)
         StIdle: begin
            if (req_take) begin
               case (apqe_pkg::opcode_type'(req_opcode))
                  apqe_pkg::OpAdd: begin
                     if (count_ff < apqe_pkg::cnt_type'(apqe_pkg::MaxParticles)) begin
                        add_en   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  apqe_pkg::OpTick: begin
                     delta_in = req_delta_time;
                     walk_in  = '0;
                     state_in = StPop;
                  end
                  apqe_pkg::OpDraw: begin
                     walk_in = '0;
                     if (count_ff != '0) begin
                        state_in = StLoad;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         StPop: begin
            // walk stays at zero, so the read slot is the head
            if (count_ff != '0 && rd_life <= 0) begin
               head_in  = apqe_pkg::slot_of(head_ff, apqe_pkg::cnt_type'(1));
               count_in = count_ff - 1'b1;
            end else if (count_ff == '0) begin
               state_in = StIdle;
            end else begin
               state_in = StDecay;
            end
         end
         StDecay: begin
            decay_en = 1'b1;
            if (walk_is_last) begin
               state_in = StIdle;
            end else begin
               walk_in = walk_ff + 1'b1;
            end
         end
         StLoad: begin
            x_lo_in = {store_x_ff[walk_slot][apqe_pkg::PosW-1], store_x_ff[walk_slot]} - half_w;
            x_hi_in = {store_x_ff[walk_slot][apqe_pkg::PosW-1], store_x_ff[walk_slot]} + half_w;
            y_lo_in = {store_y_ff[walk_slot][apqe_pkg::PosW-1], store_y_ff[walk_slot]} - half_h;
            y_hi_in = {store_y_ff[walk_slot][apqe_pkg::PosW-1], store_y_ff[walk_slot]} + half_h;
            if (half_or_less) begin
               alpha_in = apqe_pkg::AlphaFloor;
               state_in = StShow;
            end else if (full_or_more) begin
               alpha_in = apqe_pkg::AlphaMax;
               state_in = StShow;
            end else begin
               rem_in      = scaled_life[31:8];
               num_lo_in   = scaled_life[7:0];
               div_step_in = '0;
               state_in    = StDivide;
            end
         end
         StDivide: begin
            rem_in      = trial_fits ? FullW'(trial - {1'b0, full_lifetime_ff})
                                     : trial[FullW-1:0];
            num_lo_in   = {num_lo_ff[6:0], 1'b0};
            alpha_in    = {alpha_ff[6:0], trial_fits};
            div_step_in = div_step_ff + 1'b1;
            if (div_step_ff == 3'd7) begin
               state_in = StShow;
            end
         end
         StShow: begin
            rsp_load     = 1'b1;
            load_corner  = CornerTopLeft;
            corner_in    = CornerTopLeft;
            rsp_valid_in = 1'b1;
            state_in     = StEmit;
         end
         StEmit: begin
            if (!rsp_stall) begin
               if (corner_ff != CornerBottomLeft) begin
                  rsp_load    = 1'b1;
                  load_corner = corner_type'(corner_ff + 2'd1);
                  corner_in   = corner_type'(corner_ff + 2'd1);
               end else if (walk_is_last) begin
                  rsp_valid_in = 1'b0;
                  state_in     = StIdle;
               end else begin
                  rsp_valid_in = 1'b0;
                  walk_in      = walk_ff + 1'b1;
                  state_in     = StLoad;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= StIdle;
         head_ff          <= '0;
         count_ff         <= '0;
         walk_ff          <= '0;
         corner_ff        <= CornerTopLeft;
         div_step_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
         full_lifetime_ff <= apqe_pkg::FullLifetimeReset;
         base_rgb_ff      <= apqe_pkg::BaseRgbReset;
         tex_width_ff     <= apqe_pkg::TexSizeReset;
         tex_height_ff    <= apqe_pkg::TexSizeReset;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         walk_ff      <= walk_in;
         corner_ff    <= corner_in;
         div_step_ff  <= div_step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (apqe_pkg::csr_index_type'(csr_index))
               apqe_pkg::RegFullLifetime: full_lifetime_ff <= csr_data[FullW-1:0];
               apqe_pkg::RegBaseRgb:      base_rgb_ff      <= csr_data;
               apqe_pkg::RegTexWidth:     tex_width_ff     <= csr_data[apqe_pkg::TexW-1:0];
               apqe_pkg::RegTexHeight:    tex_height_ff    <= csr_data[apqe_pkg::TexW-1:0];
               default: begin
               end
            endcase
         end
      end

      delta_ff  <= delta_in;
      x_lo_ff   <= x_lo_in;
      x_hi_ff   <= x_hi_in;
      y_lo_ff   <= y_lo_in;
      y_hi_ff   <= y_hi_in;
      rem_ff    <= rem_in;
      num_lo_ff <= num_lo_in;
      alpha_ff  <= alpha_in;

      if (add_en) begin
         store_x_ff[add_slot]    <= req_pos_x;
         store_y_ff[add_slot]    <= req_pos_y;
         store_life_ff[add_slot] <= $signed({2'd0, full_lifetime_ff});
      end
      if (decay_en) begin
         store_life_ff[walk_slot] <= decay_life;
      end

      if (rsp_load) begin
         rsp_vert_x_ff <= (load_corner == CornerTopRight || load_corner == CornerBottomRight)
                        ? x_hi_ff : x_lo_ff;
         rsp_vert_y_ff <= (load_corner == CornerBottomRight || load_corner == CornerBottomLeft)
                        ? y_hi_ff : y_lo_ff;
         rsp_tex_u_ff  <= (load_corner == CornerTopRight || load_corner == CornerBottomRight)
                        ? tex_width_ff : '0;
         rsp_tex_v_ff  <= (load_corner == CornerBottomRight || load_corner == CornerBottomLeft)
                        ? tex_height_ff : '0;
         rsp_red_ff    <= base_rgb_ff[23:16];
         rsp_green_ff  <= base_rgb_ff[15:8];
         rsp_blue_ff   <= base_rgb_ff[7:0];
         rsp_alpha_ff  <= alpha_ff;
         rsp_last_ff   <= (load_corner == CornerBottomLeft) && walk_is_last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_vert_x = rsp_vert_x_ff;
   assign rsp_vert_y = rsp_vert_y_ff;
   assign rsp_tex_u  = rsp_tex_u_ff;
   assign rsp_tex_v  = rsp_tex_v_ff;
   assign rsp_red    = rsp_red_ff;
   assign rsp_green  = rsp_green_ff;
   assign rsp_blue   = rsp_blue_ff;
   assign rsp_alpha  = rsp_alpha_ff;
   assign rsp_last   = rsp_last_ff;

   count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= apqe_pkg::cnt_type'(apqe_pkg::MaxParticles))
      else $error("particle count above capacity");

   beat_only_when_emitting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == StEmit))
      else $error("output beat outside emit state");

   alpha_floor_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_alpha_ff >= apqe_pkg::AlphaFloor))
      else $error("alpha below floor");

   last_on_final_corner: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (corner_ff == CornerBottomLeft))
      else $error("last marked on a corner other than bottom-left");

   draw_never_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StLoad || state_ff == StDecay) |-> (walk_ff < count_ff))
      else $error("walk beyond stored particles");

endmodule
